FILE: sv/nsfc_pkg.sv
// shared types, constants and helper functions of the nmea sentence framer/checker
`default_nettype none

package nsfc_pkg;

  // line length limit and field cap
  localparam int LINE_BYTES = 128;
  localparam int MAX_FIELDS = 24;

  // widths
  localparam int BYTE_W     = 8;
  localparam int FILL_W     = $clog2(LINE_BYTES);
  localparam int LEN_W      = 7;
  localparam int FIELD_CNT_W = 5;
  localparam int COMMA_W    = $clog2(MAX_FIELDS);
  localparam int KIND_W     = 3;
  localparam int HEAD_LEN_W = 4;
  localparam int TAIL_W     = 24;

  // head length saturates just past the eight-character pair tag
  localparam int HEAD_LEN_SAT = 9;
  localparam int PAIR_LEN     = 8;

  // characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;

  // three-character sentence tails
  localparam logic [TAIL_W-1:0] TAIL_GGA = "GGA";
  localparam logic [TAIL_W-1:0] TAIL_RMC = "RMC";
  localparam logic [TAIL_W-1:0] TAIL_VTG = "VTG";
  localparam logic [TAIL_W-1:0] TAIL_GSA = "GSA";

  typedef enum logic [KIND_W-1:0] {
    KIND_OTHER      = 3'd0,
    KIND_GGA        = 3'd1,
    KIND_RMC        = 3'd2,
    KIND_VTG        = 3'd3,
    KIND_GSA        = 3'd4,
    KIND_RATE_REPLY = 3'd5
  } kind_t;

  // per-line tracking state
  typedef struct packed {
    logic [FILL_W-1:0]     fill;
    logic [BYTE_W-1:0]     xr;
    logic                  star;
    logic [1:0]            after_star;
    logic [BYTE_W-1:0]     hex;
    logic                  hex_stop;
    logic                  ended;
    logic [COMMA_W-1:0]    commas;
    logic                  head_open;
    logic [TAIL_W-1:0]     tail;
    logic [HEAD_LEN_W-1:0] head_len;
    logic                  pair_ok;
    logic                  second_g;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    fill:       '0,
    xr:         '0,
    star:       1'b0,
    after_star: 2'd0,
    hex:        '0,
    hex_stop:   1'b0,
    ended:      1'b0,
    commas:     '0,
    head_open:  1'b1,
    tail:       '0,
    head_len:   '0,
    pair_ok:    1'b1,
    second_g:   1'b0
  };

  // one framed-line report
  typedef struct packed {
    logic [LEN_W-1:0]       line_length;
    logic                   checksum_ok;
    logic [BYTE_W-1:0]      computed_checksum;
    logic [BYTE_W-1:0]      received_checksum;
    logic [FIELD_CNT_W-1:0] field_count;
    logic                   gnss_talker;
    logic [KIND_W-1:0]      sentence_kind;
  } result_t;

  // characters of the rate reply tag
  function automatic logic [BYTE_W-1:0] pair_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    unique case (idx)
      3'd0:    c = "$";
      3'd1:    c = "P";
      3'd2:    c = "A";
      3'd3:    c = "I";
      3'd4:    c = "R";
      3'd5:    c = "0";
      3'd6:    c = "5";
      default: c = "1";
    endcase
    return c;
  endfunction

  // hex digit decode: {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/nsfc_channels.sv
// valid/ready channel interfaces for received bytes and line reports
`default_nettype none

interface nsfc_in_if;
  logic                         valid;
  logic                         ready;
  logic [nsfc_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfc_out_if;
  logic                              valid;
  logic                              ready;
  logic [nsfc_pkg::LEN_W-1:0]        line_length;
  logic                              checksum_ok;
  logic [nsfc_pkg::BYTE_W-1:0]       computed_checksum;
  logic [nsfc_pkg::BYTE_W-1:0]       received_checksum;
  logic [nsfc_pkg::FIELD_CNT_W-1:0]  field_count;
  logic                              gnss_talker;
  logic [nsfc_pkg::KIND_W-1:0]       sentence_kind;

  modport source (output valid, output line_length, output checksum_ok,
                  output computed_checksum, output received_checksum,
                  output field_count, output gnss_talker, output sentence_kind,
                  input ready);
  modport sink   (input valid, input line_length, input checksum_ok,
                  input computed_checksum, input received_checksum,
                  input field_count, input gnss_talker, input sentence_kind,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/nsfc_line_tracker.sv
// per-byte line framing, checksum, field and head tracking with report build
`default_nettype none

module nsfc_line_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [nsfc_pkg::BYTE_W-1:0] rx_byte,
  output nsfc_pkg::result_t                result,
  output logic                             emit
);

  nsfc_pkg::line_state_t st_r, st_nxt;

  logic       is_term;
  logic [4:0] hex_dec;
  logic       head_hit;
  logic       tail_long;
  logic [nsfc_pkg::FIELD_CNT_W-1:0] fields;
  nsfc_pkg::kind_t kind;

  assign is_term = (rx_byte == nsfc_pkg::CH_CR) || (rx_byte == nsfc_pkg::CH_LF);
  assign hex_dec = nsfc_pkg::hex_decode(rx_byte);

  // head field pair-tag match on the incoming byte
  assign head_hit = (int'(st_r.head_len) < nsfc_pkg::PAIR_LEN) &&
                    (nsfc_pkg::pair_char(st_r.head_len[2:0]) == rx_byte);

  // report fields from the current line state
  assign fields    = nsfc_pkg::FIELD_CNT_W'(int'(st_r.commas) + 1);
  assign tail_long = int'(st_r.head_len) >= 3;

  always_comb begin
    kind = nsfc_pkg::KIND_OTHER;
    priority if (tail_long && st_r.tail == nsfc_pkg::TAIL_GGA) begin
      kind = nsfc_pkg::KIND_GGA;
    end else if (tail_long && st_r.tail == nsfc_pkg::TAIL_RMC) begin
      kind = nsfc_pkg::KIND_RMC;
    end else if (tail_long && st_r.tail == nsfc_pkg::TAIL_VTG) begin
      kind = nsfc_pkg::KIND_VTG;
    end else if (tail_long && st_r.tail == nsfc_pkg::TAIL_GSA) begin
      kind = nsfc_pkg::KIND_GSA;
    end else if (int'(st_r.head_len) == nsfc_pkg::PAIR_LEN && st_r.pair_ok &&
                 int'(fields) >= 2) begin
      kind = nsfc_pkg::KIND_RATE_REPLY;
    end else begin
      kind = nsfc_pkg::KIND_OTHER;
    end
  end

  always_comb begin
    result.line_length       = nsfc_pkg::LEN_W'(st_r.fill);
    result.checksum_ok       = st_r.star && (st_r.after_star >= 2'd2) &&
                               (st_r.xr == st_r.hex);
    result.computed_checksum = st_r.xr;
    result.received_checksum = st_r.star ? st_r.hex : '0;
    result.field_count       = fields;
    result.gnss_talker       = st_r.second_g;
    result.sentence_kind     = kind;
  end

  assign emit = step && is_term && (st_r.fill != '0);

  // next line state
  always_comb begin
    st_nxt = st_r;
    if (step) begin
      priority if (rx_byte == nsfc_pkg::CH_DOLLAR) begin
        // new line: dollar is the first head character
        st_nxt          = nsfc_pkg::LINE_CLEAR;
        st_nxt.fill     = nsfc_pkg::FILL_W'(1);
        st_nxt.tail     = nsfc_pkg::TAIL_W'(rx_byte);
        st_nxt.head_len = nsfc_pkg::HEAD_LEN_W'(1);
      end else if (is_term) begin
        if (st_r.fill != '0) begin
          st_nxt = nsfc_pkg::LINE_CLEAR;
        end
      end else if (st_r.fill != '0) begin
        if (st_r.fill < nsfc_pkg::FILL_W'(nsfc_pkg::LINE_BYTES - 1)) begin
          st_nxt.fill = st_r.fill + 1'b1;
          if (st_r.fill == nsfc_pkg::FILL_W'(1) && rx_byte == nsfc_pkg::CH_G) begin
            st_nxt.second_g = 1'b1;
          end
          if (!st_r.ended) begin
            priority if (rx_byte == nsfc_pkg::CH_NUL) begin
              st_nxt.ended     = 1'b1;
              st_nxt.head_open = 1'b0;
            end else if (!st_r.star) begin
              if (rx_byte == nsfc_pkg::CH_STAR) begin
                st_nxt.star      = 1'b1;
                st_nxt.head_open = 1'b0;
              end else begin
                st_nxt.xr = st_r.xr ^ rx_byte;
                if (rx_byte == nsfc_pkg::CH_COMMA) begin
                  if ((int'(st_r.commas) + 1) < nsfc_pkg::MAX_FIELDS) begin
                    st_nxt.commas = st_r.commas + 1'b1;
                  end
                  st_nxt.head_open = 1'b0;
                end else if (st_r.head_open) begin
                  // shift into head tail and track the pair tag
                  st_nxt.tail    = {st_r.tail[15:0], rx_byte};
                  st_nxt.pair_ok = st_r.pair_ok && head_hit;
                  if (int'(st_r.head_len) < nsfc_pkg::HEAD_LEN_SAT) begin
                    st_nxt.head_len = st_r.head_len + 1'b1;
                  end
                end
              end
            end else if (st_r.after_star < 2'd2) begin
              // checksum digits after the star
              st_nxt.after_star = st_r.after_star + 1'b1;
              if (!st_r.hex_stop) begin
                if (hex_dec[4]) begin
                  st_nxt.hex = {st_r.hex[3:0], hex_dec[3:0]};
                end else begin
                  st_nxt.hex_stop = 1'b1;
                end
              end
            end
          end
        end else begin
          // overflow drops the line
          st_nxt = nsfc_pkg::LINE_CLEAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= nsfc_pkg::LINE_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/nsfc_out_reg.sv
// result register driving the report channel
`default_nettype none

module nsfc_out_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  nsfc_pkg::result_t result,
  output logic             can_load,
  nsfc_out_if.source       out_ch
);

  logic              valid_r, valid_nxt;
  nsfc_pkg::result_t data_r;

  // register is free when empty or being drained this cycle
  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.line_length       = data_r.line_length;
  assign out_ch.checksum_ok       = data_r.checksum_ok;
  assign out_ch.computed_checksum = data_r.computed_checksum;
  assign out_ch.received_checksum = data_r.received_checksum;
  assign out_ch.field_count       = data_r.field_count;
  assign out_ch.gnss_talker       = data_r.gnss_talker;
  assign out_ch.sentence_kind     = data_r.sentence_kind;

endmodule

`default_nettype wire

FILE: sv/nmea_sentence_framer_checker.sv
// top level: byte input register, line tracker and report register
//
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+---------------------
//  in_ch    | in  | rx_byte[7:0]                              | valid && ready
//  out_ch   | out | line_length, checksum_ok, checksums,      | valid && ready
//           |     | field_count, gnss_talker, sentence_kind   |
//
//  one byte per cycle unless a held report stalls the tracker; a byte goes input register ->
//  tracker -> report register, so a report is registered once the tracker consumes its CR or LF
//  the line state is a registered loop inside the tracker
//  reset (rst_n low, synchronous) closes any open line and empties both registers
//  a held report stalls the tracker only when the next byte is also a CR or LF
`default_nettype none

module nmea_sentence_framer_checker (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nsfc_in_if.sink    in_ch,
  nsfc_out_if.source out_ch
);

  logic                        byte_valid_r, byte_valid_nxt;
  logic [nsfc_pkg::BYTE_W-1:0] byte_r;
  logic                        consume;
  logic                        emit;
  logic                        can_load;
  logic                        emit_possible;
  nsfc_pkg::result_t           result;

  // held byte moves on when it is no line end or the report register can take its result
  assign consume     = byte_valid_r && (can_load || !emit_possible);
  assign in_ch.ready = !byte_valid_r || consume;

  // only a line end can produce a report
  assign emit_possible = (byte_r == nsfc_pkg::CH_CR) || (byte_r == nsfc_pkg::CH_LF);

  always_comb begin
    byte_valid_nxt = byte_valid_r;
    if (in_ch.ready) begin
      byte_valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else begin
      byte_valid_r <= byte_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  nsfc_line_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .rx_byte (byte_r),
    .result  (result),
    .emit    (emit)
  );

  nsfc_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: verif/tb_nmea_sentence_framer_checker.sv
// self-checking testbench for the nmea sentence framer and checksum checker
module tb_nmea_sentence_framer_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BYTES = 500;
  localparam logic [63:0] RATE_TAG = "$PAIR051";

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsfc_in_if in_if();
  nsfc_out_if out_if();

  nmea_sentence_framer_checker u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #10 clk = ~clk;

  // bytes waiting to be sent, with a flag that holds the byte until all reports are in
  logic [7:0] rx_pending[$];
  bit         drain_first[$];
  // line being assembled by the generator
  logic [7:0] frame_q[$];
  // reports still to come from the block
  nsfc_pkg::result_t line_reports[$];

  int mismatch_count = 0;
  int cycle_count = 0;

  // shadow copy of the line tracking state
  int         ln_fill;
  logic [7:0] ln_xor;
  bit         ln_star;
  int         ln_after_star;
  logic [7:0] ln_hex;
  bit         ln_hex_stop;
  bit         ln_ended;
  int         ln_commas;
  bit         ln_head_open;
  logic [23:0] ln_tail;
  int         ln_head_len;
  bit         ln_pair_ok;
  bit         ln_second_g;

  function automatic void clear_line_state();
    ln_fill = 0;
    ln_xor = '0;
    ln_star = 1'b0;
    ln_after_star = 0;
    ln_hex = '0;
    ln_hex_stop = 1'b0;
    ln_ended = 1'b0;
    ln_commas = 0;
    ln_head_open = 1'b1;
    ln_tail = '0;
    ln_head_len = 0;
    ln_pair_ok = 1'b1;
    ln_second_g = 1'b0;
  endfunction

  // first field: keep last three chars and track the rate reply tag
  function automatic void note_head_char(input logic [7:0] b);
    ln_tail = {ln_tail[15:0], b};
    if (!(ln_head_len < 8 && RATE_TAG[63 - 8 * ln_head_len -: 8] == b)) begin
      ln_pair_ok = 1'b0;
    end
    if (ln_head_len < 127) begin
      ln_head_len++;
    end
  endfunction

  // one text byte of an open line
  function automatic void absorb_text(input logic [7:0] b);
    int digit;
    if (ln_fill == 1 && b == nsfc_pkg::CH_G) begin
      ln_second_g = 1'b1;
    end
    if (ln_ended) begin
      return;
    end
    if (b == nsfc_pkg::CH_NUL) begin
      ln_ended = 1'b1;
      ln_head_open = 1'b0;
    end else if (!ln_star) begin
      if (b == nsfc_pkg::CH_STAR) begin
        ln_star = 1'b1;
        ln_head_open = 1'b0;
      end else begin
        ln_xor ^= b;
        if (b == nsfc_pkg::CH_COMMA) begin
          if (ln_commas + 1 < nsfc_pkg::MAX_FIELDS) begin
            ln_commas++;
          end
          ln_head_open = 1'b0;
        end else if (ln_head_open) begin
          note_head_char(b);
        end
      end
    end else if (ln_after_star < 2) begin
      ln_after_star++;
      if (!ln_hex_stop) begin
        digit = -1;
        if (b >= "0" && b <= "9") begin
          digit = int'(b) - 48;
        end else if (b >= "A" && b <= "F") begin
          digit = int'(b) - 55;
        end else if (b >= "a" && b <= "f") begin
          digit = int'(b) - 87;
        end
        if (digit < 0) begin
          ln_hex_stop = 1'b1;
        end else begin
          ln_hex = {ln_hex[3:0], 4'(digit)};
        end
      end
    end
  endfunction

  // advance the shadow state by one accepted byte, queue the report of a closed line
  function automatic void predict_line(input logic [7:0] b);
    nsfc_pkg::result_t rep;
    nsfc_pkg::kind_t   kind;
    int                fields;
    if (b == nsfc_pkg::CH_DOLLAR) begin
      clear_line_state();
      ln_fill = 1;
      note_head_char(b);
      return;
    end
    if (b == nsfc_pkg::CH_CR || b == nsfc_pkg::CH_LF) begin
      if (ln_fill == 0) begin
        return;
      end
      fields = ln_commas + 1;
      kind = nsfc_pkg::KIND_OTHER;
      if (ln_head_len >= 3 && ln_tail == nsfc_pkg::TAIL_GGA) begin
        kind = nsfc_pkg::KIND_GGA;
      end else if (ln_head_len >= 3 && ln_tail == nsfc_pkg::TAIL_RMC) begin
        kind = nsfc_pkg::KIND_RMC;
      end else if (ln_head_len >= 3 && ln_tail == nsfc_pkg::TAIL_VTG) begin
        kind = nsfc_pkg::KIND_VTG;
      end else if (ln_head_len >= 3 && ln_tail == nsfc_pkg::TAIL_GSA) begin
        kind = nsfc_pkg::KIND_GSA;
      end else if (ln_head_len == 8 && ln_pair_ok && fields >= 2) begin
        kind = nsfc_pkg::KIND_RATE_REPLY;
      end
      rep.line_length       = 7'(ln_fill);
      rep.checksum_ok       = ln_star && ln_after_star >= 2 && ln_xor == ln_hex;
      rep.computed_checksum = ln_xor;
      rep.received_checksum = ln_star ? ln_hex : 8'h00;
      rep.field_count       = 5'(fields);
      rep.gnss_talker       = ln_second_g;
      rep.sentence_kind     = kind;
      line_reports.push_back(rep);
      clear_line_state();
      return;
    end
    if (ln_fill == 0) begin
      return;
    end
    if (ln_fill < nsfc_pkg::LINE_BYTES - 1) begin
      absorb_text(b);
      ln_fill++;
    end else begin
      clear_line_state();
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic void put(input logic [7:0] b);
    frame_q.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    foreach (s[i]) begin
      frame_q.push_back(s[i]);
    end
  endfunction

  function automatic void send_frame(input bit hold);
    foreach (frame_q[i]) begin
      rx_pending.push_back(frame_q[i]);
      drain_first.push_back(hold && i == 0);
    end
    frame_q = {};
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(33, 126));
    end while (c == nsfc_pkg::CH_DOLLAR || c == nsfc_pkg::CH_STAR ||
               c == nsfc_pkg::CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] upper_letter();
    return 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return 8'(48 + n);
    end
    return 8'((lower ? 87 : 55) + n);
  endfunction

  // well-formed sentence with random content and a random checksum tail
  function automatic void gen_sentence(input bit hold);
    logic [7:0] sum;
    int head_sel, n_fields, n_chars, i, j;
    put(nsfc_pkg::CH_DOLLAR);
    head_sel = $urandom_range(0, 9);
    if (head_sel < 4) begin
      put(($urandom_range(0, 3) != 0) ? nsfc_pkg::CH_G : upper_letter());
      put(upper_letter());
      case (head_sel)
        0: put_text("GGA");
        1: put_text("RMC");
        2: put_text("VTG");
        default: put_text("GSA");
      endcase
    end else if (head_sel < 6) begin
      put_text("PAIR051");
      if ($urandom_range(0, 3) == 0) begin
        put(field_char());
      end
    end else if (head_sel < 7) begin
      put_text("PAIR05");
      put(field_char());
    end else begin
      n_chars = $urandom_range(0, 6);
      for (j = 0; j < n_chars; j++) begin
        put(field_char());
      end
    end
    n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 5);
    for (i = 0; i < n_fields; i++) begin
      put(nsfc_pkg::CH_COMMA);
      n_chars = $urandom_range(0, 4);
      for (j = 0; j < n_chars; j++) begin
        put(field_char());
      end
    end
    // zero byte ends the text early
    if ($urandom_range(0, 15) == 0) begin
      put(nsfc_pkg::CH_NUL);
      put(field_char());
    end
    sum = '0;
    for (i = 1; i < frame_q.size(); i++) begin
      if (frame_q[i] == nsfc_pkg::CH_NUL) begin
        break;
      end
      sum ^= frame_q[i];
    end
    case ($urandom_range(0, 7))
      0, 1: begin
        put(nsfc_pkg::CH_STAR);
        put(hex_char(sum[7:4], 1'b0));
        put(hex_char(sum[3:0], 1'b0));
      end
      2: begin
        put(nsfc_pkg::CH_STAR);
        put(hex_char(sum[7:4], 1'b1));
        put(hex_char(sum[3:0], 1'b1));
      end
      3: begin
        sum ^= 8'($urandom_range(1, 255));
        put(nsfc_pkg::CH_STAR);
        put(hex_char(sum[7:4], 1'b0));
        put(hex_char(sum[3:0], 1'b0));
      end
      4: begin
        put(nsfc_pkg::CH_STAR);
        put(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      5: ;
      6: begin
        put(nsfc_pkg::CH_STAR);
        put(field_char());
        put(field_char());
      end
      default: begin
        put(nsfc_pkg::CH_STAR);
        put(hex_char(sum[7:4], 1'b0));
        put(hex_char(sum[3:0], 1'b0));
        n_chars = $urandom_range(1, 3);
        for (j = 0; j < n_chars; j++) begin
          put(field_char());
        end
      end
    endcase
    case ($urandom_range(0, 2))
      0: put(nsfc_pkg::CH_CR);
      1: put(nsfc_pkg::CH_LF);
      default: begin
        put(nsfc_pkg::CH_CR);
        put(nsfc_pkg::CH_LF);
      end
    endcase
    send_frame(hold);
  endfunction

  // ---------------- sender: bursts with random gaps ----------------
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.rx_byte <= '0;
      clear_line_state();
    end else begin
      // transfer of a byte
      if (in_if.valid && in_if.ready) begin
        predict_line(in_if.rx_byte);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (rx_pending.size() != 0 &&
                     !(drain_first[0] && line_reports.size() != 0)) begin
          in_if.valid <= 1'b1;
          in_if.rx_byte <= rx_pending.pop_front();
          void'(drain_first.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver: stall pattern and report check ----------------
  int stall_mode = 0;
  int stall_tick = 0;

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    nsfc_pkg::result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      // transfer of a report
      if (out_if.valid && out_if.ready) begin
        if (line_reports.size() == 0) begin
          $error("line report with no expectation pending");
          mismatch_count++;
        end else begin
          want = line_reports.pop_front();
          check_field("line_length", 8'(want.line_length), 8'(out_if.line_length));
          check_field("checksum_ok", 8'(want.checksum_ok), 8'(out_if.checksum_ok));
          check_field("computed_checksum", want.computed_checksum,
                      out_if.computed_checksum);
          check_field("received_checksum", want.received_checksum,
                      out_if.received_checksum);
          check_field("field_count", 8'(want.field_count), 8'(out_if.field_count));
          check_field("gnss_talker", 8'(want.gnss_talker), 8'(out_if.gnss_talker));
          check_field("sentence_kind", 8'(want.sentence_kind), 8'(out_if.sentence_kind));
        end
      end
      stall_tick++;
      if (stall_tick % 48 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= (stall_tick % 5 == 0);
        default: out_if.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("nmea_sentence_framer_checker test failed");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int sentences;
    int overflows;
    int pick;
    int n;
    int j;
    bit hold;
    sentences = 0;
    overflows = 0;

    // directed: stray terminator and byte, short lines, dollar mid-line,
    // zero byte, one and two chars after the star
    put(nsfc_pkg::CH_LF);
    put(8'hFF);
    put(nsfc_pkg::CH_DOLLAR);
    put(nsfc_pkg::CH_G);
    put(nsfc_pkg::CH_CR);
    put_text("$X$GSA,");
    put(nsfc_pkg::CH_NUL);
    put_text("*7");
    put(nsfc_pkg::CH_LF);
    put_text("$*0");
    put(nsfc_pkg::CH_CR);
    put_text("$*00");
    put(nsfc_pkg::CH_CR);
    send_frame(1'b0);

    // random part
    while (rx_pending.size() < RANDOM_BYTES) begin
      hold = (sentences == 0) || ($urandom_range(0, 39) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        gen_sentence(hold);
        sentences++;
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++) begin
          put(8'($urandom_range(0, 255)));
        end
        send_frame(hold);
      end else if (pick < 93) begin
        // line cut short, usually restarted by the next dollar
        put(nsfc_pkg::CH_DOLLAR);
        n = $urandom_range(1, 8);
        for (j = 0; j < n; j++) begin
          put(field_char());
        end
        send_frame(hold);
      end else if (pick < 97 || overflows >= 5) begin
        put(($urandom_range(0, 1) == 0) ? nsfc_pkg::CH_CR : nsfc_pkg::CH_LF);
        send_frame(hold);
      end else begin
        // around the longest line the block holds
        put(nsfc_pkg::CH_DOLLAR);
        n = $urandom_range(124, 128);
        for (j = 0; j < n; j++) begin
          put(field_char());
        end
        put(nsfc_pkg::CH_CR);
        overflows++;
        send_frame(hold);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_pending.size() != 0 || in_if.valid) begin
      @(posedge clk);
    end
    while (line_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && line_reports.size() == 0) begin
      $display("nmea_sentence_framer_checker test passed");
    end else begin
      $display("nmea_sentence_framer_checker test failed");
    end
    $finish;
  end

endmodule
